[rtl/core/oorq_pkg.sv]
// Shared types and codes for the overwrite-oldest ring queue.
// Used by oorq_ctrl and overwrite_oldest_ring_queue; no dependencies.
`timescale 1ns / 1ps

package oorq_pkg;

  // Widths fixed by the item and register fields
  localparam int DATA_W      = 64;
  localparam int LIMIT_W     = 5;
  localparam int ELEM_W      = 4;
  localparam int COUNT_W     = 5;
  localparam int STATUS_W    = 2;
  localparam int MAX_BYTES   = 8;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 5;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_QUEUE_LIMIT   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ELEMENT_BYTES = 2'd1;

  // Reset values of the configuration registers
  localparam logic [LIMIT_W-1:0] QUEUE_LIMIT_RST   = 5'd16;
  localparam logic [ELEM_W-1:0]  ELEMENT_BYTES_RST = 4'd0;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_UNCFG = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  // Per-item result info from the control logic to the result path
  typedef struct packed {
    status_t              status;
    logic                 overwrote;
    logic [COUNT_W-1:0]   fill_count;
    logic                 pop_ok;
    logic [MAX_BYTES-1:0] byte_en;
  } info_t;

endpackage

[rtl/core/oorq_ctrl.sv]
// Queue control: head/tail pointers, fill count, and per-item decision.
// Depends on oorq_pkg.
`timescale 1ns / 1ps

module oorq_ctrl #(
  parameter int MAX_ENTRIES = 16,
  parameter int DATA_BYTES  = 8,
  parameter int PTR_W       = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic                          operation,
  input  logic [oorq_pkg::LIMIT_W-1:0]  queue_limit,
  input  logic [oorq_pkg::ELEM_W-1:0]   element_bytes,
  output oorq_pkg::info_t               info,
  output logic                          wr_en,
  output logic [PTR_W-1:0]              wr_addr,
  output logic                          rd_en,
  output logic [PTR_W-1:0]              rd_addr
);

  // Largest limit the 5-bit register can express against the ring depth
  localparam int LimCap = (MAX_ENTRIES < 31) ? MAX_ENTRIES : 31;

  logic [PTR_W-1:0]               head, head_next;
  logic [PTR_W-1:0]               tail, tail_next;
  logic [oorq_pkg::COUNT_W-1:0]   count, count_next;
  logic [oorq_pkg::LIMIT_W-1:0]   lim;
  logic [oorq_pkg::ELEM_W-1:0]    nbytes;
  logic [oorq_pkg::MAX_BYTES-1:0] byte_en;
  logic                           full;
  logic                           pop_ok;
  logic                           push_ok;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    if (p == PTR_W'(MAX_ENTRIES - 1)) n = '0;
    else n = p + PTR_W'(1);
    return n;
  endfunction

  // Effective limit: zero acts as one, clamp to ring depth
  always_comb begin
    if (queue_limit == '0) begin
      lim = oorq_pkg::LIMIT_W'(1);
    end else if (32'(queue_limit) > 32'(LimCap)) begin
      lim = oorq_pkg::LIMIT_W'(LimCap);
    end else begin
      lim = queue_limit;
    end
  end

  // Element size clamped to storage width, expanded to byte enables
  always_comb begin
    if (32'(element_bytes) > 32'(DATA_BYTES)) nbytes = oorq_pkg::ELEM_W'(DATA_BYTES);
    else nbytes = element_bytes;
    for (int i = 0; i < oorq_pkg::MAX_BYTES; i++) begin
      byte_en[i] = (oorq_pkg::ELEM_W'(i) < nbytes);
    end
  end

  assign full = (count >= lim);

  // Item decision and next pointer state
  always_comb begin
    head_next       = head;
    tail_next       = tail;
    count_next      = count;
    info.status     = oorq_pkg::STAT_OK;
    info.overwrote  = 1'b0;
    pop_ok          = 1'b0;
    push_ok         = 1'b0;
    if (element_bytes == '0) begin
      info.status = oorq_pkg::STAT_UNCFG;
    end else if (operation == oorq_pkg::OP_PUSH) begin
      push_ok = 1'b1;
      if (full) begin
        // drop the oldest entry; count stays the same
        head_next      = ptr_inc(head);
        info.overwrote = 1'b1;
      end else begin
        count_next = count + oorq_pkg::COUNT_W'(1);
      end
      tail_next = ptr_inc(tail);
    end else if (count == '0) begin
      info.status = oorq_pkg::STAT_EMPTY;
    end else begin
      pop_ok     = 1'b1;
      head_next  = ptr_inc(head);
      count_next = count - oorq_pkg::COUNT_W'(1);
    end
    info.pop_ok     = pop_ok;
    info.fill_count = count_next;
    info.byte_en    = byte_en;
  end

  assign wr_en   = accept & push_ok;
  assign wr_addr = tail;
  assign rd_en   = accept & pop_ok;
  assign rd_addr = head;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (accept) begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

endmodule

[rtl/core/overwrite_oldest_ring_queue.sv]
// Top level of the overwrite-oldest ring queue: config registers, slot memory,
// read stage and result register. Depends on oorq_pkg and oorq_ctrl.
// Each result passes through the read stage and then the result register.
// Throughput: one item per cycle unless rsp_ready stalls; at most one slot write or read per item.
// Reset: pointers and fill count clear, queue_limit is 16, element_bytes is 0
// (unconfigured); slot contents are not cleared.
`timescale 1ns / 1ps

module overwrite_oldest_ring_queue #(
  parameter int MAX_ENTRIES = 16,
  parameter int DATA_BYTES  = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [oorq_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [oorq_pkg::CFG_DATA_W-1:0]   cfg_data,
  // request channel
  input  logic                              req_valid,
  output logic                              req_ready,
  input  logic                              operation,
  input  logic [oorq_pkg::DATA_W-1:0]       data_in,
  // response channel
  output logic                              rsp_valid,
  input  logic                              rsp_ready,
  output logic [oorq_pkg::STATUS_W-1:0]     status,
  output logic [oorq_pkg::DATA_W-1:0]       data_out,
  output logic                              overwrote,
  output logic [oorq_pkg::COUNT_W-1:0]      fill_count
);

  localparam int DataW = DATA_BYTES * 8;
  localparam int PtrW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  logic [oorq_pkg::LIMIT_W-1:0] queue_limit;
  logic [oorq_pkg::ELEM_W-1:0]  element_bytes;

  oorq_pkg::info_t  info;
  oorq_pkg::info_t  s1_info;
  logic             s1_valid;
  logic             wr_en, rd_en;
  logic [PtrW-1:0]  wr_addr, rd_addr;
  logic [DataW-1:0] wr_mask, rd_mask;
  logic [DataW-1:0] wr_data;
  logic [DataW-1:0] rd_data;
  logic [DataW-1:0] slots [MAX_ENTRIES];
  logic             rsp_free;
  logic             s1_adv;
  logic             accept;

  // Handshake: read stage advances when the result register is free
  assign rsp_free  = !rsp_valid || rsp_ready;
  assign s1_adv    = s1_valid && rsp_free;
  assign req_ready = !s1_valid || rsp_free;
  assign accept    = req_valid && req_ready;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      queue_limit   <= oorq_pkg::QUEUE_LIMIT_RST;
      element_bytes <= oorq_pkg::ELEMENT_BYTES_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        oorq_pkg::CFG_QUEUE_LIMIT:   queue_limit   <= cfg_data;
        oorq_pkg::CFG_ELEMENT_BYTES: element_bytes <= cfg_data[oorq_pkg::ELEM_W-1:0];
        default: ;
      endcase
    end
  end

  oorq_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .DATA_BYTES  (DATA_BYTES),
    .PTR_W       (PtrW)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .operation     (operation),
    .queue_limit   (queue_limit),
    .element_bytes (element_bytes),
    .info          (info),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr)
  );

  // Byte masks for the write data and for the popped entry
  always_comb begin
    for (int i = 0; i < DATA_BYTES; i++) begin
      wr_mask[i*8 +: 8] = {8{info.byte_en[i]}};
      rd_mask[i*8 +: 8] = {8{s1_info.byte_en[i]}};
    end
  end

  assign wr_data = data_in[DataW-1:0] & wr_mask;

  // Slot memory: one write at tail, registered read at head
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= slots[rd_addr];
    end
  end

  // Read stage: holds the item info while the slot read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_info <= info;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_free) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      status     <= s1_info.status;
      overwrote  <= s1_info.overwrote;
      fill_count <= s1_info.fill_count;
      data_out   <= s1_info.pop_ok ? oorq_pkg::DATA_W'(rd_data & rd_mask) : '0;
    end
  end

endmodule

[tb/testbench.sv]
// Self-checking bench for the overwrite-oldest ring queue: directed and random push/pop
// items under several register settings, with bursty requests and a stalling response side.
// Depends on oorq_pkg and overwrite_oldest_ring_queue.
`timescale 1ns / 1ps

module testbench;

  localparam int DEPTH          = 16;
  localparam int NUM_PHASES     = 16;
  localparam int PHASE_ITEMS    = 50;
  localparam int IDLE_GAP       = 6;
  localparam int CYCLE_LIMIT    = 500000;

  typedef struct {
    oorq_pkg::op_t               op;
    logic [oorq_pkg::DATA_W-1:0] word;
  } access_item_t;

  typedef struct {
    oorq_pkg::status_t            status;
    logic [oorq_pkg::DATA_W-1:0]  word;
    logic                         overwrote;
    logic [oorq_pkg::COUNT_W-1:0] fill;
  } access_result_t;

  logic                             clk;
  logic                             rst = 1'b1;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [oorq_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [oorq_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                             req_valid = 1'b0;
  logic                             req_ready;
  logic                             operation = 1'b0;
  logic [oorq_pkg::DATA_W-1:0]      data_in = '0;
  logic                             rsp_valid;
  logic                             rsp_ready = 1'b0;
  logic [oorq_pkg::STATUS_W-1:0]    status;
  logic [oorq_pkg::DATA_W-1:0]      data_out;
  logic                             overwrote;
  logic [oorq_pkg::COUNT_W-1:0]     fill_count;

  overwrite_oldest_ring_queue i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .operation  (operation),
    .data_in    (data_in),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .status     (status),
    .data_out   (data_out),
    .overwrote  (overwrote),
    .fill_count (fill_count)
  );

  // Items waiting to be sent, and results the queue still owes us
  access_item_t   pending_items[$];
  access_result_t awaited_results[$];
  access_item_t   next_item;
  access_result_t front_result;

  // Shadow copy of the queue state and registers
  logic [oorq_pkg::DATA_W-1:0]  shadow_slots [DEPTH];
  int                           shadow_head;
  int                           shadow_tail;
  int                           shadow_count;
  logic [oorq_pkg::LIMIT_W-1:0] shadow_limit;
  logic [oorq_pkg::ELEM_W-1:0]  shadow_ebytes;

  // Handshake flags raised at the rising edge, read at the falling edge
  logic req_taken = 1'b0;
  logic cfg_taken = 1'b0;

  int burst_left    = 8;
  int gap_left      = 0;
  int stall_mode    = 0;
  int stall_hold    = 0;
  int mismatches    = 0;
  int cycles        = 0;
  int added_items   = 0;
  int checked_items = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // One push or pop applied to the shadow queue; returns the result it should produce
  function automatic access_result_t predict_access(oorq_pkg::op_t op,
                                                    logic [oorq_pkg::DATA_W-1:0] word);
    access_result_t              r;
    int                          lim;
    int                          nb;
    logic [oorq_pkg::DATA_W-1:0] keep;
    r.status    = oorq_pkg::STAT_OK;
    r.word      = '0;
    r.overwrote = 1'b0;
    lim = (shadow_limit == 0) ? 1 : ((shadow_limit > DEPTH) ? DEPTH : int'(shadow_limit));
    nb  = (shadow_ebytes > oorq_pkg::MAX_BYTES) ? oorq_pkg::MAX_BYTES : int'(shadow_ebytes);
    keep = (nb >= 8) ? '1 : ((64'd1 << (8 * nb)) - 64'd1);
    if (shadow_ebytes == 0) begin
      r.status = oorq_pkg::STAT_UNCFG;
    end else if (op == oorq_pkg::OP_PUSH) begin
      // full: drop the oldest entry first
      if (shadow_count >= lim) begin
        shadow_head = (shadow_head + 1) % DEPTH;
        shadow_count--;
        r.overwrote = 1'b1;
      end
      shadow_slots[shadow_tail] = word & keep;
      shadow_tail = (shadow_tail + 1) % DEPTH;
      shadow_count++;
    end else if (shadow_count == 0) begin
      r.status = oorq_pkg::STAT_EMPTY;
    end else begin
      r.word = shadow_slots[shadow_head] & keep;
      shadow_head = (shadow_head + 1) % DEPTH;
      shadow_count--;
    end
    r.fill = oorq_pkg::COUNT_W'(shadow_count);
    return r;
  endfunction

  function automatic logic [oorq_pkg::DATA_W-1:0] random_word();
    case ($urandom_range(0, 9))
      0:       return '1;
      1:       return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic add_item(oorq_pkg::op_t op, logic [oorq_pkg::DATA_W-1:0] word);
    access_item_t it;
    it.op   = op;
    it.word = word;
    pending_items.push_back(it);
    added_items++;
  endtask

  // Register write on the config channel; the queue must be idle
  task automatic write_reg(logic [oorq_pkg::CFG_INDEX_W-1:0] idx,
                           logic [oorq_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every item is sent and answered, then a few quiet cycles
  task automatic settle();
    do @(negedge clk);
    while (checked_items != added_items);
    repeat (IDLE_GAP) @(negedge clk);
  endtask

  // Request driver: bursts of items with random gaps
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req_valid && !req_taken) begin
      // hold the current item
    end else if (gap_left > 0) begin
      gap_left--;
      req_valid <= 1'b0;
    end else if (pending_items.size() > 0) begin
      next_item = pending_items.pop_front();
      req_valid <= 1'b1;
      operation <= next_item.op;
      data_in   <= next_item.word;
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      end
    end else begin
      req_valid <= 1'b0;
    end
  end

  // Response side: stall pattern switches between always ready, random and mostly stalled
  always @(negedge clk) begin
    if (stall_hold == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_hold = $urandom_range(10, 80);
    end
    stall_hold--;
    case (stall_mode)
      0:       rsp_ready <= 1'b1;
      1:       rsp_ready <= 1'($urandom_range(0, 1));
      default: rsp_ready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  // Monitor: track register writes, predict accepted items, check results
  always @(posedge clk) begin
    req_taken = 1'b0;
    cfg_taken = 1'b0;
    if (rst) begin
      shadow_head   = 0;
      shadow_tail   = 0;
      shadow_count  = 0;
      shadow_limit  = oorq_pkg::QUEUE_LIMIT_RST;
      shadow_ebytes = oorq_pkg::ELEMENT_BYTES_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cfg_taken = 1'b1;
        case (cfg_index)
          oorq_pkg::CFG_QUEUE_LIMIT:   shadow_limit  = cfg_data[oorq_pkg::LIMIT_W-1:0];
          oorq_pkg::CFG_ELEMENT_BYTES: shadow_ebytes = cfg_data[oorq_pkg::ELEM_W-1:0];
          default: ;
        endcase
      end
      if (req_valid && req_ready) begin
        req_taken = 1'b1;
        awaited_results.push_back(predict_access(oorq_pkg::op_t'(operation), data_in));
      end
      if (rsp_valid && rsp_ready) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result: status %0d data_out %h", status, data_out);
          mismatches++;
        end else begin
          front_result = awaited_results.pop_front();
          checked_items++;
          if (status !== front_result.status) begin
            $error("status: expected %0d, got %0d", front_result.status, status);
            mismatches++;
          end
          if (data_out !== front_result.word) begin
            $error("data_out: expected %h, got %h", front_result.word, data_out);
            mismatches++;
          end
          if (overwrote !== front_result.overwrote) begin
            $error("overwrote: expected %0d, got %0d", front_result.overwrote, overwrote);
            mismatches++;
          end
          if (fill_count !== front_result.fill) begin
            $error("fill_count: expected %0d, got %0d", front_result.fill, fill_count);
            mismatches++;
          end
        end
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Stimulus
  initial begin
    int push_pct;
    int lim_val;
    int eb_val;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Unconfigured after reset: both operations rejected
    add_item(oorq_pkg::OP_PUSH, '1);
    add_item(oorq_pkg::OP_POP, '0);
    settle();

    // Full width, small limit: empty pop, fill, overwrite, pops
    write_reg(oorq_pkg::CFG_QUEUE_LIMIT, 5'd4);
    write_reg(oorq_pkg::CFG_ELEMENT_BYTES, 5'd8);
    add_item(oorq_pkg::OP_POP, '0);
    add_item(oorq_pkg::OP_PUSH, '1);
    add_item(oorq_pkg::OP_PUSH, '0);
    add_item(oorq_pkg::OP_PUSH, 64'h0123_4567_89ab_cdef);
    add_item(oorq_pkg::OP_PUSH, 64'hfedc_ba98_7654_3210);
    add_item(oorq_pkg::OP_PUSH, 64'h8000_0000_0000_0001);
    add_item(oorq_pkg::OP_POP, '0);
    add_item(oorq_pkg::OP_POP, '0);
    settle();

    // Element size shrunk while holding entries
    write_reg(oorq_pkg::CFG_ELEMENT_BYTES, 5'd3);
    add_item(oorq_pkg::OP_POP, '0);
    add_item(oorq_pkg::OP_POP, '0);
    add_item(oorq_pkg::OP_POP, '0);
    add_item(oorq_pkg::OP_PUSH, '1);
    settle();

    // Element size above the data width acts as full width
    write_reg(oorq_pkg::CFG_ELEMENT_BYTES, 5'd15);
    add_item(oorq_pkg::OP_POP, '0);
    repeat (4) add_item(oorq_pkg::OP_PUSH, '1);
    settle();

    // Limit lowered while full: one entry dropped per push
    write_reg(oorq_pkg::CFG_QUEUE_LIMIT, 5'd2);
    add_item(oorq_pkg::OP_PUSH, 64'h5555_aaaa_5555_aaaa);
    settle();

    // Limit zero acts as one
    write_reg(oorq_pkg::CFG_QUEUE_LIMIT, 5'd0);
    add_item(oorq_pkg::OP_PUSH, 64'haaaa_5555_aaaa_5555);
    repeat (4) add_item(oorq_pkg::OP_POP, '0);
    add_item(oorq_pkg::OP_PUSH, 64'h1);
    add_item(oorq_pkg::OP_PUSH, 64'h2);
    settle();

    // Random phases, each under its own register setting
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       begin lim_val = 31; eb_val = 8;  end
        1:       begin lim_val = 1;  eb_val = 1;  end
        2:       begin lim_val = 16; eb_val = 15; end
        3:       begin lim_val = 0;  eb_val = 0;  end
        4:       begin lim_val = 17; eb_val = 4;  end
        default: begin
          lim_val = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
          eb_val  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
        end
      endcase
      write_reg(oorq_pkg::CFG_QUEUE_LIMIT, oorq_pkg::CFG_DATA_W'(lim_val));
      write_reg(oorq_pkg::CFG_ELEMENT_BYTES, oorq_pkg::CFG_DATA_W'(eb_val));
      // push-heavy phases overwrite, pop-heavy ones drain to empty
      case ($urandom_range(0, 3))
        0:       push_pct = 25;
        1:       push_pct = 50;
        2:       push_pct = 75;
        default: push_pct = 90;
      endcase
      if (p == 0) push_pct = 90;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(1, 100) <= push_pct) add_item(oorq_pkg::OP_PUSH, random_word());
        else add_item(oorq_pkg::OP_POP, random_word());
      end
      settle();
    end

    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/oorq_pkg.sv
rtl/core/oorq_ctrl.sv
rtl/core/overwrite_oldest_ring_queue.sv
tb/testbench.sv
